// ===== rtl/cicd_pkg.sv =====
// Shared types and constants for the multichannel CIC decimator.
package cicd_pkg;

    localparam int CH_W       = 2;
    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 16;
    localparam int FACTOR_W   = 11;
    localparam int ACC_W      = 64;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);
    localparam int PEND_W     = OUTQ_LVL_W + 2;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(4);
    localparam logic [CODE_W-1:0]   CODE_MAX     = '1;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic [CODE_W-1:0] filtered_sample;
    } out_word_t;

    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  ch;
        logic [ACC_W-1:0] acc;
    } int_to_comb_t;

    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  ch;
        logic [ACC_W-1:0] comb;
    } comb_to_out_t;

endpackage

// ===== rtl/multichannel_cic_decimator_unit.sv =====
// Top level of the multichannel CIC decimator.
// Input channel: in_valid/in_ready carry in_word (channel tag and raw 16-bit sample).
// Output channel: out_valid/out_ready carry out_word (channel and filtered code).
// cfg_we/cfg_wdata write the decimation factor; write only while the block is idle.
// One input word is taken per cycle while in_ready is high, also for the same channel back
// to back: the integrator and comb state live in two RAMs, each read ahead and written
// back in the cycle after, with a one-entry forward covering consecutive words on a channel.
// A completing word passes the comb and rounding registers into the output queue.
// Words for channels beyond CHANNELS are taken and dropped.
// Reset clears the per-entry valid bits so all filter state reads as zero, and sets
// the factor to 4; no clearing pass is needed.
// The output side has a 4-word queue; in_ready drops when words in flight plus queued
// words reach 4 and no word leaves the queue in that cycle, so a stalled receiver
// holds the input back without loss.
module multichannel_cic_decimator_unit import cicd_pkg::*; #(
    parameter int CHANNELS = 4,
    parameter int STAGES   = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output out_word_t           out_word,
    input  logic                cfg_we,
    input  logic [FACTOR_W-1:0] cfg_wdata
);

    logic [FACTOR_W-1:0]   factor_reg;
    logic                  start;
    logic                  in_range;
    logic                  busy1;
    logic                  busy2;
    logic                  busy3;
    logic [OUTQ_LVL_W-1:0] level;
    logic [PEND_W-1:0]     pend;
    int_to_comb_t          i2c;
    comb_to_out_t          c2o;

    assign in_range = (32'(in_word.channel) < CHANNELS);
    assign pend     = PEND_W'(busy1) + PEND_W'(busy2) + PEND_W'(busy3) + PEND_W'(level);
    assign in_ready = (pend < PEND_W'(OUTQ_DEPTH) + PEND_W'(out_valid & out_ready));
    assign start    = in_valid & in_ready & in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            factor_reg <= cfg_wdata;
        end
    end

    cicd_integ #(
        .CHANNELS(CHANNELS),
        .STAGES  (STAGES)
    ) u_integ (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .in_word(in_word),
        .factor (factor_reg),
        .busy   (busy1),
        .to_comb(i2c)
    );

    cicd_comb #(
        .CHANNELS(CHANNELS),
        .STAGES  (STAGES)
    ) u_comb (
        .clk       (clk),
        .rst_n     (rst_n),
        .from_integ(i2c),
        .busy      (busy2),
        .to_out    (c2o)
    );

    cicd_outq #(
        .STAGES(STAGES)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .from_comb(c2o),
        .busy     (busy3),
        .level    (level),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word)
    );

endmodule

// ===== rtl/cicd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cicd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cicd_integ.sv =====
// Integrator and decimation-counter stage: read-modify-write of per-channel state.
module cicd_integ import cicd_pkg::*; #(
    parameter int CHANNELS = 4,
    parameter int STAGES   = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  in_word_t            in_word,
    input  logic [FACTOR_W-1:0] factor,
    output logic                busy,
    output int_to_comb_t        to_comb
);

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int INT_W  = STAGES * ACC_W;
    localparam int WORD_W = INT_W + FACTOR_W;

    typedef logic [STAGES-1:0][ACC_W-1:0] integ_vec_t;

    logic                v1_reg;
    logic [CH_W-1:0]     ch1_reg;
    logic [SAMPLE_W-1:0] smp1_reg;
    logic                fwd_v_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic [WORD_W-1:0]   fwd_word_reg;
    logic [CHANNELS-1:0] ent_vld_reg;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       addr1;
    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   old_word;
    integ_vec_t          old_int;
    integ_vec_t          new_int;
    logic [FACTOR_W-1:0] old_cnt;
    logic [FACTOR_W-1:0] cnt_inc;
    logic [FACTOR_W-1:0] cnt_next;
    logic                decim;
    logic [WORD_W-1:0]   word_next;

    assign rd_addr = AW'(in_word.channel);
    assign addr1   = AW'(ch1_reg);

    cicd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CHANNELS)
    ) u_ram (
        .clk  (clk),
        .we   (v1_reg),
        .waddr(addr1),
        .wdata(word_next),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    always_comb
    begin
        if (fwd_v_reg && (fwd_addr_reg == addr1))
        begin
            old_word = fwd_word_reg;
        end
        else if (ent_vld_reg[addr1])
        begin
            old_word = rdata;
        end
        else
        begin
            old_word = '0;
        end
    end

    assign old_int = integ_vec_t'(old_word[INT_W-1:0]);
    assign old_cnt = old_word[WORD_W-1 -: FACTOR_W];

    // each integrator adds the updated value of the one before it
    always_comb
    begin
        logic [ACC_W-1:0] run;
        run = ACC_W'(smp1_reg);
        for (int s = 0; s < STAGES; s++)
        begin
            run        = run + old_int[s];
            new_int[s] = run;
        end
    end

    assign cnt_inc   = old_cnt + FACTOR_W'(1);
    assign decim     = (cnt_inc >= factor);
    assign cnt_next  = decim ? '0 : cnt_inc;
    assign word_next = {cnt_next, new_int};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            fwd_v_reg   <= 1'b0;
            ent_vld_reg <= '0;
        end
        else
        begin
            v1_reg    <= start;
            fwd_v_reg <= v1_reg;
            if (v1_reg)
            begin
                ent_vld_reg[addr1] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch1_reg      <= in_word.channel;
        smp1_reg     <= in_word.sample;
        fwd_addr_reg <= addr1;
        fwd_word_reg <= word_next;
    end

    assign busy          = v1_reg;
    assign to_comb.valid = v1_reg & decim;
    assign to_comb.ch    = ch1_reg;
    assign to_comb.acc   = new_int[STAGES-1];

endmodule

// ===== rtl/cicd_comb.sv =====
// Comb stage: read-modify-write of per-channel comb delays on decimation.
module cicd_comb import cicd_pkg::*; #(
    parameter int CHANNELS = 4,
    parameter int STAGES   = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  int_to_comb_t from_integ,
    output logic         busy,
    output comb_to_out_t to_out
);

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W = STAGES * ACC_W;

    typedef logic [STAGES-1:0][ACC_W-1:0] delay_vec_t;

    logic                v2_reg;
    logic [CH_W-1:0]     ch2_reg;
    logic [ACC_W-1:0]    acc2_reg;
    logic                fwd_v_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic [WORD_W-1:0]   fwd_word_reg;
    logic [CHANNELS-1:0] ent_vld_reg;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       addr2;
    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   old_word;
    delay_vec_t          old_dly;
    delay_vec_t          new_dly;
    logic [ACC_W-1:0]    comb_val;

    assign rd_addr = AW'(from_integ.ch);
    assign addr2   = AW'(ch2_reg);

    cicd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CHANNELS)
    ) u_ram (
        .clk  (clk),
        .we   (v2_reg),
        .waddr(addr2),
        .wdata(new_dly),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    always_comb
    begin
        if (fwd_v_reg && (fwd_addr_reg == addr2))
        begin
            old_word = fwd_word_reg;
        end
        else if (ent_vld_reg[addr2])
        begin
            old_word = rdata;
        end
        else
        begin
            old_word = '0;
        end
    end

    assign old_dly = delay_vec_t'(old_word);

    always_comb
    begin
        logic [ACC_W-1:0] c;
        c = acc2_reg;
        for (int s = 0; s < STAGES; s++)
        begin
            new_dly[s] = c;
            c          = c - old_dly[s];
        end
        comb_val = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg      <= 1'b0;
            fwd_v_reg   <= 1'b0;
            ent_vld_reg <= '0;
        end
        else
        begin
            v2_reg    <= from_integ.valid;
            fwd_v_reg <= v2_reg;
            if (v2_reg)
            begin
                ent_vld_reg[addr2] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch2_reg      <= from_integ.ch;
        acc2_reg     <= from_integ.acc;
        fwd_addr_reg <= addr2;
        fwd_word_reg <= new_dly;
    end

    assign busy         = v2_reg;
    assign to_out.valid = v2_reg;
    assign to_out.ch    = ch2_reg;
    assign to_out.comb  = comb_val;

endmodule

// ===== rtl/cicd_outq.sv =====
// Rounding, gain shift and clamp, then the output word queue.
module cicd_outq import cicd_pkg::*; #(
    parameter int STAGES = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  comb_to_out_t          from_comb,
    output logic                  busy,
    output logic [OUTQ_LVL_W-1:0] level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    localparam int               GAIN_SHIFT = 2 * STAGES;
    localparam logic [ACC_W-1:0] BIAS       = ACC_W'(1) << (GAIN_SHIFT - 1);

    logic                  v3_reg;
    logic [CH_W-1:0]       ch3_reg;
    logic [ACC_W-1:0]      comb3_reg;
    out_word_t             q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_LVL_W-1:0] cnt_reg;
    logic [OUTQ_LVL_W-1:0] cnt_next;

    logic [ACC_W-1:0]      biased;
    logic [ACC_W-1:0]      shifted;
    logic [CODE_W-1:0]     code;
    logic                  pop;
    out_word_t             push_word;

    assign biased  = comb3_reg + BIAS;
    assign shifted = biased >> GAIN_SHIFT;

    always_comb
    begin
        priority if (biased[ACC_W-1])
        begin
            code = '0;
        end
        else if (shifted >= ACC_W'(CODE_MAX))
        begin
            code = CODE_MAX;
        end
        else
        begin
            code = shifted[CODE_W-1:0];
        end
    end

    assign push_word.out_channel     = ch3_reg;
    assign push_word.filtered_sample = code;

    assign pop      = out_valid & out_ready;
    assign cnt_next = cnt_reg + OUTQ_LVL_W'(v3_reg) - OUTQ_LVL_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            v3_reg  <= from_comb.valid;
            cnt_reg <= cnt_next;
            if (v3_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch3_reg   <= from_comb.ch;
        comb3_reg <= from_comb.comb;
        if (v3_reg)
        begin
            q_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign busy      = v3_reg;
    assign level     = cnt_reg;
    assign out_valid = (cnt_reg != '0);
    assign out_word  = q_reg[rd_ptr_reg];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multichannel CIC decimator unit.
module testbench;
    import cicd_pkg::*;

    localparam int NUM_CH       = 4;
    localparam int NUM_STAGES   = 2;
    localparam int GAIN_SHIFT   = 2 * NUM_STAGES;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int RESET_CYCLES = 6;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_word_t            in_word   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_word_t           out_word;
    logic                cfg_we    = 1'b0;
    logic [FACTOR_W-1:0] cfg_wdata = '0;

    // filter state mirror
    logic [ACC_W-1:0]    integ_q    [NUM_CH][NUM_STAGES];
    logic [ACC_W-1:0]    comb_dly_q [NUM_CH][NUM_STAGES];
    logic [FACTOR_W-1:0] decim_cnt  [NUM_CH];
    logic [FACTOR_W-1:0] factor_q;

    in_word_t  adc_backlog[$];
    out_word_t filtered_due[$];
    out_word_t due_word;

    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    int       tx_burst       = 1;
    int       tx_gap         = 0;
    bit       tx_hold        = 1'b0;
    int       rx_left        = 0;
    rx_mode_t rx_mode        = RX_OPEN;

    multichannel_cic_decimator_unit #(
        .CHANNELS(NUM_CH),
        .STAGES  (NUM_STAGES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic void cic_decimate_step(input in_word_t w);
        int               ch;
        int               s;
        logic [ACC_W-1:0] comb;
        logic [ACC_W-1:0] delayed;
        logic [ACC_W-1:0] biased;
        logic [ACC_W-1:0] shifted;
        out_word_t        res;
        ch = int'(w.channel);
        if (ch >= NUM_CH)
            return;
        integ_q[ch][0] = integ_q[ch][0] + ACC_W'(w.sample);
        for (s = 1; s < NUM_STAGES; s++)
            integ_q[ch][s] = integ_q[ch][s] + integ_q[ch][s-1];
        decim_cnt[ch] = decim_cnt[ch] + 1'b1;
        if (decim_cnt[ch] < factor_q)
            return;
        decim_cnt[ch] = '0;
        comb = integ_q[ch][NUM_STAGES-1];
        for (s = 0; s < NUM_STAGES; s++)
        begin
            delayed = comb_dly_q[ch][s];
            comb_dly_q[ch][s] = comb;
            comb = comb - delayed;
        end
        biased = comb + (ACC_W'(1) << (GAIN_SHIFT - 1));
        res.out_channel = w.channel;
        if (biased[ACC_W-1])
            res.filtered_sample = '0;
        else
        begin
            shifted = biased >> GAIN_SHIFT;
            if (shifted >= ACC_W'(CODE_MAX))
                res.filtered_sample = CODE_MAX;
            else
                res.filtered_sample = shifted[CODE_W-1:0];
        end
        filtered_due.push_back(res);
    endfunction

    // driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            cic_decimate_step(in_word);
        if (!in_valid || in_ready)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (adc_backlog.size() > 0 && !tx_hold)
            begin
                in_word  <= adc_backlog.pop_front();
                in_valid <= 1'b1;
                if (tx_burst > 1)
                    tx_burst--;
                else
                begin
                    tx_burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
                    tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (filtered_due.size() == 0)
                report_mismatch($sformatf("word with nothing expected: ch %0d value %0d",
                                          out_word.out_channel, out_word.filtered_sample));
            else
            begin
                due_word = filtered_due.pop_front();
                if (out_word.out_channel !== due_word.out_channel)
                    report_mismatch($sformatf("out_channel got %0d expected %0d",
                                              out_word.out_channel, due_word.out_channel));
                if (out_word.filtered_sample !== due_word.filtered_sample)
                    report_mismatch($sformatf("ch %0d filtered_sample got %0d expected %0d",
                                              due_word.out_channel, out_word.filtered_sample,
                                              due_word.filtered_sample));
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 48);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (rx_left % 6 == 0);
            default:   out_ready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** multichannel_cic_decimator_unit: FAILED **");
            $finish;
        end
    end

    task automatic push_word(input int ch, input logic [SAMPLE_W-1:0] smp);
        in_word_t w;
        w.channel = CH_W'(ch);
        w.sample  = smp;
        adc_backlog.push_back(w);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (adc_backlog.size() != 0 || in_valid || filtered_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_factor(input logic [FACTOR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        factor_q = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop the sender mid-stream until everything in flight has come out
    task automatic hold_sender();
        while (adc_backlog.size() > 5)
            @(negedge clk);
        tx_hold = 1'b1;
        do
            @(negedge clk);
        while (filtered_due.size() != 0 || in_valid);
        repeat ($urandom_range(1, 20)) @(negedge clk);
        tx_hold = 1'b0;
    endtask

    task automatic run_random_phase(input logic [FACTOR_W-1:0] factor, input int count,
                                    input bit pause_mid);
        int i;
        int ch;
        int last_ch;
        last_ch = 0;
        wait_idle();
        write_factor(factor);
        for (i = 0; i < count; i++)
        begin
            ch = ($urandom_range(0, 2) == 0) ? last_ch : $urandom_range(0, NUM_CH - 1);
            push_word(ch, random_sample());
            last_ch = ch;
            if (pause_mid && i == count / 2)
                hold_sender();
        end
    endtask

    initial
    begin
        int k;
        int i;
        logic [FACTOR_W-1:0] phase_factor;
        for (k = 0; k < NUM_CH; k++)
        begin
            decim_cnt[k] = '0;
            for (i = 0; i < NUM_STAGES; i++)
            begin
                integ_q[k][i]    = '0;
                comb_dly_q[k][i] = '0;
            end
        end
        factor_q = FACTOR_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset factor, interleaved channels with full-scale and zero codes
        push_word(0, 16'h0000);
        push_word(1, 16'hFFFF);
        push_word(0, 16'hFFFF);
        push_word(1, 16'hFFFF);
        push_word(0, 16'h0000);
        push_word(1, 16'hFFFF);
        push_word(0, 16'hFFFF);
        push_word(1, 16'hFFFF);

        // zero factor decimates on every word
        wait_idle();
        write_factor(11'd0);
        push_word(0, 16'h0000);
        push_word(1, 16'hFFFF);
        push_word(2, 16'h0001);
        push_word(3, 16'h8000);

        // spacing change drives the comb output negative
        wait_idle();
        write_factor(11'd4);
        for (i = 0; i < 4; i++)
            push_word(2, 16'hFFFF);
        wait_idle();
        write_factor(11'd1);
        push_word(2, 16'h0000);
        push_word(2, 16'h0000);

        // factor lowered below the running counter
        wait_idle();
        write_factor(11'd7);
        for (i = 0; i < 5; i++)
            push_word(3, 16'h7FFF + 16'(i));
        wait_idle();
        write_factor(11'd2);
        push_word(3, 16'h1234);

        for (k = 0; k < 9; k++)
        begin
            case (k)
                0:       phase_factor = 11'd1;
                1:       phase_factor = 11'd2;
                2:       phase_factor = 11'd3;
                3:       phase_factor = 11'd5;
                4:       phase_factor = 11'd8;
                5:       phase_factor = 11'd0;
                6:       phase_factor = 11'd16;
                7:       phase_factor = FACTOR_W'($urandom_range(1, 12));
                default: phase_factor = 11'd4;
            endcase
            run_random_phase(phase_factor, 35, (k == 0) || ($urandom_range(0, 2) == 0));
        end

        // large factors hold off decimation; a factor of one then flushes both channels
        wait_idle();
        write_factor(11'd1024);
        for (i = 0; i < 12; i++)
            push_word(0, random_sample());
        wait_idle();
        write_factor(11'd2047);
        for (i = 0; i < 12; i++)
            push_word(3, random_sample());
        wait_idle();
        write_factor(11'd1);
        push_word(0, random_sample());
        push_word(3, random_sample());
        run_random_phase(11'd3, 30, 1'b0);

        wait_idle();
        if (mismatch_count == 0)
            $display("** multichannel_cic_decimator_unit: PASSED **");
        else
            $display("** multichannel_cic_decimator_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cicd_pkg.sv
rtl/cicd_ram.sv
rtl/cicd_integ.sv
rtl/cicd_comb.sv
rtl/cicd_outq.sv
rtl/multichannel_cic_decimator_unit.sv
tb/testbench.sv
